// ===== design/agmu_pkg.sv =====
`timescale 1ns / 1ps

package agmu_pkg;

  // Field and register widths
  localparam int IDX_W       = 12;
  localparam int Q_W         = 32;
  localparam int MOM_W       = 17;
  localparam int LR_W        = 24;
  localparam int MIN_GAIN_W  = 17;
  localparam int CFG_DATA_W  = 24;
  localparam int CFG_INDEX_W = 2;

  // Default geometry of the embedding
  localparam int POINTS_DEFAULT = 2048;
  localparam int DIMS_DEFAULT   = 2;
  localparam int IDX_SPAN       = 1 << IDX_W;

  // Buffering
  localparam int QUEUE_DEPTH = 4;
  localparam int OUT_DEPTH   = 16;
  localparam int OUT_CNT_W   = $clog2(OUT_DEPTH + 1);

  // Register reset values, unsigned Q16.16
  localparam logic [MOM_W-1:0]      MOMENTUM_RESET      = 17'd32768;
  localparam logic [LR_W-1:0]       LEARNING_RATE_RESET = 24'd13107200;
  localparam logic [MIN_GAIN_W-1:0] MIN_GAIN_RESET      = 17'd655;

  // Gain adaptation constants, Q16.16
  localparam logic [Q_W-1:0] GAIN_ONE    = 32'h0001_0000;
  localparam logic [15:0]    GAIN_SHRINK = 16'd52429;
  localparam logic [Q_W-1:0] GAIN_GROW   = 32'd13107;
  localparam logic [15:0]    ROUND_HALF  = 16'h8000;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_MOMENTUM      = 2'd0,
    REG_LEARNING_RATE = 2'd1,
    REG_MIN_GAIN      = 2'd2
  } reg_index_t;

  typedef struct packed {
    logic [IDX_W-1:0]        element_index;
    logic signed [Q_W-1:0]   gradient;
    logic signed [Q_W-1:0]   position;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0]        out_index;
    logic signed [Q_W-1:0]   new_position;
    logic signed [Q_W-1:0]   new_increment;
  } out_item_t;

  // Classified request passed from the front to the back
  typedef struct packed {
    logic [IDX_W-1:0]        index;
    logic                    stored;
    logic                    grad_pos;
    logic                    grad_neg;
    logic [Q_W-1:0]          grad_mag;
    logic signed [Q_W-1:0]   position;
  } req_t;

  // One row of the per-element state memory
  typedef struct packed {
    logic [Q_W-1:0]          gain;
    logic signed [Q_W-1:0]   increment;
  } entry_t;

endpackage

// ===== design/agmu_fifo.sv =====
`timescale 1ns / 1ps

// DEPTH must be a power of two, at least 2.
module agmu_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  input  logic [WIDTH-1:0]             din,
  input  logic                         pop,
  output logic [WIDTH-1:0]             dout,
  output logic                         empty,
  output logic                         full,
  output logic [$clog2(DEPTH+1)-1:0]   count
);

  localparam int PTR_W = $clog2(DEPTH);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic             do_push;
  logic             do_pop;

  assign empty   = (count == '0);
  assign full    = (count == ($clog2(DEPTH+1))'(DEPTH));
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= din;
    end
  end

endmodule

// ===== design/agmu_front.sv =====
`timescale 1ns / 1ps

module agmu_front
  import agmu_pkg::*;
#(
  parameter int POINTS = POINTS_DEFAULT,
  parameter int DIMS   = DIMS_DEFAULT
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  output logic     full,
  input  in_item_t item,
  input  logic     hold,
  output logic     q_push,
  output req_t     q_req,
  input  logic     q_full
);

  localparam int ELEMS = POINTS * DIMS;

  logic valid;
  req_t held;
  req_t sorted;
  logic take;

  assign full   = hold || (valid && q_full);
  assign take   = push && !full;
  assign q_push = valid && !q_full;
  assign q_req  = held;

  // Classify: tag elements that have a row in the state memory, split the gradient
  always_comb begin
    sorted.index    = item.element_index;
    sorted.stored   = 32'(item.element_index) < 32'(ELEMS);
    sorted.grad_neg = item.gradient[Q_W-1];
    sorted.grad_pos = !item.gradient[Q_W-1] && (item.gradient != '0);
    sorted.grad_mag = item.gradient[Q_W-1] ? Q_W'(-item.gradient) : Q_W'(item.gradient);
    sorted.position = item.position;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (take) begin
      valid <= 1'b1;
    end else if (q_push) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      held <= sorted;
    end
  end

endmodule

// ===== design/agmu_back.sv =====
`timescale 1ns / 1ps

module agmu_back
  import agmu_pkg::*;
#(
  parameter int POINTS = POINTS_DEFAULT,
  parameter int DIMS   = DIMS_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   head_empty,
  input  req_t                   head,
  output logic                   head_pop,
  output logic                   clearing,
  input  logic [OUT_CNT_W-1:0]   out_count,
  output logic                   res_valid,
  output out_item_t              res
);

  localparam int ELEMS  = POINTS * DIMS;
  localparam int DEPTH  = (ELEMS < IDX_SPAN) ? ELEMS : IDX_SPAN;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int WB     = 8;
  localparam int LAST   = 9;

  logic [MOM_W-1:0]      momentum;
  logic [LR_W-1:0]       learning_rate;
  logic [MIN_GAIN_W-1:0] min_gain;

  entry_t              store [DEPTH];
  entry_t              rd_entry;
  entry_t              wr_entry;
  logic                wr_en;
  logic [ADDR_W-1:0]   wr_addr;
  logic [ADDR_W-1:0]   clr_addr;

  logic                issue;
  logic                hazard;
  logic                room;
  logic [OUT_CNT_W-1:0] inflight;
  logic [LAST:1]       vld;
  req_t                req_s [1:WB];

  logic [Q_W-1:0]        cur_gain;
  logic signed [Q_W-1:0] cur_inc;
  logic [Q_W-1:0]        cur_inc_mag;
  logic [Q_W:0]          gadd_wide;

  logic [47:0]           gmul_s2;
  logic [Q_W-1:0]        gadd_s2;
  logic                  shrink_s2;
  logic [48:0]           mprod_s2;
  logic                  vneg_s2;

  logic [47:0]           gm_round;
  logic [48:0]           mt_round;
  logic [Q_W-1:0]        gsel;
  logic [Q_W-1:0]        gnew;

  logic [Q_W-1:0]        gain_s [3:WB];
  logic [Q_W-1:0]        mt_s3;
  logic                  vneg_s3;

  logic [55:0]           sprod_s4;
  logic signed [Q_W:0]   mom_s [4:7];
  logic [55:0]           step_round;
  logic [39:0]           step_s5;
  logic [63:0]           plo_s6;
  logic [39:0]           phi_s6;
  logic [71:0]           gt_sum;
  logic [55:0]           gt_s7;

  logic signed [57:0]    mom_wide;
  logic signed [57:0]    diff;
  logic signed [Q_W-1:0] ninc;
  logic signed [Q_W-1:0] ninc_s8;
  logic signed [Q_W:0]   psum;
  logic signed [Q_W-1:0] npos;
  out_item_t             res_s9;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      momentum      <= MOMENTUM_RESET;
      learning_rate <= LEARNING_RATE_RESET;
      min_gain      <= MIN_GAIN_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_MOMENTUM:      momentum      <= cfg_data[MOM_W-1:0];
        REG_LEARNING_RATE: learning_rate <= cfg_data[LR_W-1:0];
        REG_MIN_GAIN:      min_gain      <= cfg_data[MIN_GAIN_W-1:0];
        default:           momentum      <= momentum;
      endcase
    end
  end

  // Clearing sweep after reset: one row a cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == ADDR_W'(DEPTH - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  // Hold the head while its element is still on the way to write-back
  always_comb begin
    hazard = 1'b0;
    for (int k = 1; k <= WB; k++) begin
      if (vld[k] && req_s[k].stored && head.stored && (req_s[k].index == head.index)) begin
        hazard = 1'b1;
      end
    end
  end

  assign room     = ({1'b0, inflight} + {1'b0, out_count}) < (OUT_CNT_W + 1)'(OUT_DEPTH);
  assign issue    = !head_empty && !clearing && !hazard && room;
  assign head_pop = issue;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld      <= '0;
      inflight <= '0;
    end else begin
      vld      <= {vld[LAST-1:1], issue};
      inflight <= inflight + OUT_CNT_W'(issue) - OUT_CNT_W'(vld[LAST]);
    end
  end

  // State memory
  always_comb begin
    wr_en = clearing || (vld[WB] && req_s[WB].stored);
    if (clearing) begin
      wr_addr            = clr_addr;
      wr_entry.gain      = GAIN_ONE;
      wr_entry.increment = '0;
    end else begin
      wr_addr            = req_s[WB].index[ADDR_W-1:0];
      wr_entry.gain      = gain_s[WB];
      wr_entry.increment = ninc_s8;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store[wr_addr] <= wr_entry;
    end
    if (issue) begin
      rd_entry <= store[head.index[ADDR_W-1:0]];
    end
  end

  // Stage 1 -> 2: pick state, start gain and momentum products
  always_comb begin
    cur_gain    = req_s[1].stored ? rd_entry.gain : GAIN_ONE;
    cur_inc     = req_s[1].stored ? rd_entry.increment : '0;
    cur_inc_mag = cur_inc[Q_W-1] ? Q_W'(-cur_inc) : Q_W'(cur_inc);
    gadd_wide   = {1'b0, cur_gain} + {1'b0, GAIN_GROW};
  end

  // Stage 2 -> 3: round, select and clamp the gain
  always_comb begin
    gm_round = gmul_s2 + 48'(ROUND_HALF);
    mt_round = mprod_s2 + 49'(ROUND_HALF);
    gsel     = shrink_s2 ? gm_round[47:16] : gadd_s2;
    gnew     = (gsel < Q_W'(min_gain)) ? Q_W'(min_gain) : gsel;
  end

  // Later stages
  always_comb begin
    step_round = sprod_s4 + 56'(ROUND_HALF);
    gt_sum     = {phi_s6, 32'b0} + 72'(plo_s6) + 72'(ROUND_HALF);
    mom_wide   = {{(58 - Q_W - 1){mom_s[7][Q_W]}}, mom_s[7]};
    diff       = req_s[7].grad_neg ? mom_wide + $signed({2'b00, gt_s7})
                                   : mom_wide - $signed({2'b00, gt_s7});
    if ((&diff[57:Q_W-1]) || !(|diff[57:Q_W-1])) begin
      ninc = diff[Q_W-1:0];
    end else if (diff[57]) begin
      ninc = {1'b1, {(Q_W-1){1'b0}}};
    end else begin
      ninc = {1'b0, {(Q_W-1){1'b1}}};
    end
    psum = {req_s[WB].position[Q_W-1], req_s[WB].position} + {ninc_s8[Q_W-1], ninc_s8};
    if (psum[Q_W] == psum[Q_W-1]) begin
      npos = psum[Q_W-1:0];
    end else if (psum[Q_W]) begin
      npos = {1'b1, {(Q_W-1){1'b0}}};
    end else begin
      npos = {1'b0, {(Q_W-1){1'b1}}};
    end
  end

  // Datapath registers; advance every cycle
  always_ff @(posedge clk) begin
    req_s[1] <= head;
    for (int k = 2; k <= WB; k++) begin
      req_s[k] <= req_s[k-1];
    end

    gmul_s2   <= 48'(cur_gain) * 48'(GAIN_SHRINK);
    gadd_s2   <= gadd_wide[Q_W] ? '1 : gadd_wide[Q_W-1:0];
    shrink_s2 <= req_s[1].grad_pos && !cur_inc[Q_W-1] && (cur_inc != '0);
    mprod_s2  <= 49'(momentum) * 49'(cur_inc_mag);
    vneg_s2   <= cur_inc[Q_W-1];

    gain_s[3] <= gnew;
    mt_s3     <= mt_round[47:16];
    vneg_s3   <= vneg_s2;
    for (int k = 4; k <= WB; k++) begin
      gain_s[k] <= gain_s[k-1];
    end

    sprod_s4 <= 56'(learning_rate) * 56'(gain_s[3]);
    mom_s[4] <= vneg_s3 ? -$signed({1'b0, mt_s3}) : $signed({1'b0, mt_s3});
    for (int k = 5; k <= 7; k++) begin
      mom_s[k] <= mom_s[k-1];
    end

    step_s5 <= step_round[55:16];
    plo_s6  <= 64'(step_s5[31:0]) * 64'(req_s[5].grad_mag);
    phi_s6  <= 40'(step_s5[39:32]) * 40'(req_s[5].grad_mag);
    gt_s7   <= gt_sum[71:16];
    ninc_s8 <= ninc;

    res_s9.out_index     <= req_s[WB].index;
    res_s9.new_position  <= npos;
    res_s9.new_increment <= ninc_s8;
  end

  assign res_valid = vld[LAST];
  assign res       = res_s9;

endmodule

// ===== design/adaptive_gain_momentum_update_unit.sv =====
`timescale 1ns / 1ps

// Gain-adapted momentum step for one embedding element per request, in signed
// Q16.16. Each request names an element, brings its gradient and position, and
// returns the updated position and increment; the element's gain and increment
// are kept in an on-chip state memory of min(POINTS*DIMS, 4096) rows. Requests
// go in through a queue-like push/full port and results come out through an
// empty/pop port in request order. The block takes one request per clock and
// delivers one result per clock while the result queue has room and no request
// waits on its element. The limit is the read-modify-write of the state
// memory: a request for an element that is still in the nine-stage update
// pipeline waits at the head of the internal queue until that element is
// written back, while requests for other elements stream at full rate. After
// reset a clearing sweep writes every row of the state memory, one row per
// cycle, and full stays high until the sweep is done; configuration writes are
// taken during the sweep.
// Write momentum, learning rate and minimum gain only while the block is idle.
// Indices at or above POINTS*DIMS are computed from gain 1.0 and increment 0
// and leave no state behind.
module adaptive_gain_momentum_update_unit
  import agmu_pkg::*;
#(
  parameter int POINTS = POINTS_DEFAULT,
  parameter int DIMS   = DIMS_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  output logic                   full,
  input  in_item_t               item,
  output logic                   empty,
  input  logic                   pop,
  output out_item_t              result,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int REQ_W = $bits(req_t);
  localparam int RES_W = $bits(out_item_t);

  logic                 clearing;
  logic                 q_push;
  req_t                 q_req;
  logic                 q_full;
  logic                 q_empty;
  logic [REQ_W-1:0]     q_head_bits;
  req_t                 q_head;
  logic                 q_pop;
  logic                 res_valid;
  out_item_t            res;
  logic [OUT_CNT_W-1:0] out_count;
  logic [RES_W-1:0]     out_head_bits;

  // Front: take the request, tag stored elements, split the gradient into sign
  // and magnitude. Hold full high while the state memory is being cleared.
  agmu_front #(
    .POINTS (POINTS),
    .DIMS   (DIMS)
  ) u_front (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .full   (full),
    .item   (item),
    .hold   (clearing),
    .q_push (q_push),
    .q_req  (q_req),
    .q_full (q_full)
  );

  // Short queue between front and back: let either side stall on its own.
  agmu_fifo #(
    .WIDTH (REQ_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_req_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .din   (q_req),
    .pop   (q_pop),
    .dout  (q_head_bits),
    .empty (q_empty),
    .full  (q_full),
    .count ()
  );

  assign q_head = req_t'(q_head_bits);

  // Back: issue into the update pipeline when the element is free and the
  // result queue has room for everything already in flight.
  agmu_back #(
    .POINTS (POINTS),
    .DIMS   (DIMS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .head_empty (q_empty),
    .head       (q_head),
    .head_pop   (q_pop),
    .clearing   (clearing),
    .out_count  (out_count),
    .res_valid  (res_valid),
    .res        (res)
  );

  // Result queue: decouple the pipeline from the consumer. Never overflows,
  // since the back counts its in-flight requests against the free slots.
  agmu_fifo #(
    .WIDTH (RES_W),
    .DEPTH (OUT_DEPTH)
  ) u_res_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (res_valid),
    .din   (res),
    .pop   (pop),
    .dout  (out_head_bits),
    .empty (empty),
    .full  (),
    .count (out_count)
  );

  assign result = out_item_t'(out_head_bits);

endmodule

// ===== design/agmu_checker.sv =====
`timescale 1ns / 1ps

module agmu_checker
  import agmu_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      push,
  input logic      full,
  input logic      empty,
  input logic      pop,
  input out_item_t result
);

  localparam int MAX_PENDING = 1 + QUEUE_DEPTH + OUT_DEPTH;

  logic [5:0] pending;

  // Track requests taken but not yet answered
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + 6'(push && !full) - 6'(pop && !empty);
    end
  end

  a_reset_state: assert property (@(posedge clk) rst |=> (empty && full))
    else $error("agmu: not empty and full after reset");

  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (pending != '0))
    else $error("agmu: result shown with no request outstanding");

  a_bounded: assert property (@(posedge clk) disable iff (rst)
    pending <= 6'(MAX_PENDING))
    else $error("agmu: more requests taken than the buffers hold");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(result)))
    else $error("agmu: waiting result changed or vanished");

endmodule

bind adaptive_gain_momentum_update_unit agmu_checker u_agmu_checker (
  .clk    (clk),
  .rst    (rst),
  .push   (push),
  .full   (full),
  .empty  (empty),
  .pop    (pop),
  .result (result)
);

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps

// Self-checking bench for the adaptive gain / momentum update unit.
// Requests go in through the push/full port and results are drained through the
// empty/pop port. Each accepted request is run through a local model of the
// per-element gain and increment memories; its output, or a typed-in result,
// is queued; each popped result is compared field by field with the oldest entry.
module testbench;
  import agmu_pkg::*;

  // Elements that own a row of state; indices at or above this are stateless
  localparam int ELEMS = (POINTS_DEFAULT * DIMS_DEFAULT < IDX_SPAN) ?
                         POINTS_DEFAULT * DIMS_DEFAULT : IDX_SPAN;

  // Register slot that decodes to nothing; writes to it must be dropped
  localparam logic [CFG_INDEX_W-1:0] REG_NONE = 2'd3;

  localparam logic signed [Q_W-1:0] Q_MAX = 32'h7FFF_FFFF;
  localparam logic signed [Q_W-1:0] Q_MIN = 32'h8000_0000;
  localparam longint SAT_HI = 2147483647;
  localparam longint SAT_LO = -SAT_HI - 1;

  // Cycles without any handshake before the run is abandoned. Covers the
  // clearing sweep after reset (one row per cycle), the longest sender gap,
  // the pipeline latency and the same-element hold-off, several times over.
  localparam int STALL_LIMIT = 20000;

  // Settled cycles after the last result
  localparam int DRAIN_CYCLES = 32;

  localparam int PHASES         = 7;
  localparam int ITEMS_PER_PHASE = 215;

  typedef struct packed {
    in_item_t  req;
    logic      known;
    out_item_t want;
  } directed_row_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   push = 1'b0;
  logic                   full;
  in_item_t               in_req = '0;
  logic                   empty;
  logic                   pop = 1'b0;
  out_item_t              result;
  logic                   cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  // Local copy of the block's registers and per-element memories
  logic [MOM_W-1:0]      momentum_q;
  logic [LR_W-1:0]       learning_rate_q;
  logic [MIN_GAIN_W-1:0] min_gain_q;
  logic [Q_W-1:0]        gain_of [ELEMS];
  int                    increment_of [ELEMS];

  out_item_t     pending_updates[$];
  directed_row_t directed_rows[$];

  int fail_count     = 0;
  int requests_sent  = 0;
  int results_seen   = 0;
  int settings_used  = 0;
  int shrink_count   = 0;
  int clamp_count    = 0;
  int idle_cycles    = 0;

  always #4 clk = ~clk;

  adaptive_gain_momentum_update_unit DUT (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .item      (in_req),
    .empty     (empty),
    .pop       (pop),
    .result    (result),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // ---------------------------------------------------------------------------
  // Model of the update
  // ---------------------------------------------------------------------------

  // (a * b + 0.5) >> 16, split so that no partial product overflows 64 bits
  function automatic logic [63:0] mul_q16(logic [63:0] a, logic [63:0] b);
    return a * (b >> 16) + ((a * (b & 64'hFFFF) + 64'(ROUND_HALF)) >> 16);
  endfunction

  function automatic logic signed [Q_W-1:0] sat_q16(longint v);
    if (v > SAT_HI) return Q_MAX;
    if (v < SAT_LO) return Q_MIN;
    return v[Q_W-1:0];
  endfunction

  // Advance one element by one descent step and return what the block should emit
  function automatic out_item_t step_element(in_item_t req);
    logic [IDX_W-1:0] idx;
    bit               stored;
    logic [63:0]      gain, step, mom_mag, grad_mag, inc_mag;
    int               g, p, inc32, ninc, npos;
    longint           grad, inc, mom_term, grad_term;
    out_item_t        r;
    idx    = req.element_index;
    stored = idx < ELEMS;
    g      = req.gradient;
    p      = req.position;
    inc32  = stored ? increment_of[idx] : 0;
    grad   = g;
    inc    = inc32;
    gain   = stored ? 64'(gain_of[idx]) : 64'(GAIN_ONE);

    // Shrink the gain only when gradient and old increment are both positive
    if (grad > 0 && inc > 0) begin
      gain = (gain * 64'(GAIN_SHRINK) + 64'(ROUND_HALF)) >> 16;
      shrink_count++;
    end else begin
      gain = gain + 64'(GAIN_GROW);
      if (gain > 64'hFFFF_FFFF) gain = 64'hFFFF_FFFF;
    end
    if (gain < 64'(min_gain_q)) begin
      gain = 64'(min_gain_q);
      clamp_count++;
    end

    // Both terms round their magnitude half up, then take the sign back
    inc_mag   = (inc < 0) ? 64'(-inc) : 64'(inc);
    mom_mag   = mul_q16(64'(momentum_q), inc_mag);
    mom_term  = (inc < 0) ? -longint'(mom_mag) : longint'(mom_mag);
    step      = (64'(learning_rate_q) * gain + 64'(ROUND_HALF)) >> 16;
    grad_mag  = (grad < 0) ? 64'(-grad) : 64'(grad);
    grad_mag  = mul_q16(step, grad_mag);
    grad_term = (grad < 0) ? -longint'(grad_mag) : longint'(grad_mag);

    ninc = sat_q16(mom_term - grad_term);
    npos = sat_q16(longint'(p) + longint'(ninc));

    if (stored) begin
      gain_of[idx]      = gain[Q_W-1:0];
      increment_of[idx] = ninc;
    end
    r.out_index     = idx;
    r.new_position  = npos;
    r.new_increment = ninc;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Random value helpers
  // ---------------------------------------------------------------------------

  // Magnitude of random bit length, mostly well below full scale
  function automatic logic [Q_W-1:0] draw_magnitude(int max_bits);
    return $urandom & ((32'd1 << $urandom_range(0, max_bits)) - 32'd1);
  endfunction

  // Any signed Q16.16 value: zero, full-width noise, the rails or a modest number
  function automatic logic signed [Q_W-1:0] draw_value();
    logic [Q_W-1:0] m;
    m = draw_magnitude(24);
    case ($urandom_range(0, 7))
      0: return '0;
      1: return $urandom;
      2: return $urandom_range(0, 1) ? Q_MAX : Q_MIN;
      default: return $urandom_range(0, 1) ? -m : m;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // Both drivers are entered just after a falling edge and leave at one.
  bit send_steady = 1'b0;

  task automatic send_request(in_item_t req, bit known, out_item_t want);
    int        gap;
    out_item_t predicted;
    if (requests_sent % 32 == 0) send_steady = ($urandom_range(0, 3) == 0);
    gap = send_steady ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      push = 1'b0;
      repeat (gap) @(negedge clk);
    end
    push   = 1'b1;
    in_req = req;
    do @(posedge clk); while (full !== 1'b0);
    // Always advance the model; a typed-in result overrides its output
    predicted = step_element(req);
    pending_updates.push_back(known ? want : predicted);
    requests_sent++;
    @(negedge clk);
  endtask

  task automatic write_register(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    case (idx)
      REG_MOMENTUM:      momentum_q      = data[MOM_W-1:0];
      REG_LEARNING_RATE: learning_rate_q = data[LR_W-1:0];
      REG_MIN_GAIN:      min_gain_q      = data[MIN_GAIN_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_write = 1'b0;
  endtask

  // Drop push and hold until every request has come back out
  task automatic wait_idle();
    push = 1'b0;
    while (pending_updates.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic add_row(logic [IDX_W-1:0] idx, logic [Q_W-1:0] grad, logic [Q_W-1:0] pos,
                         bit known, logic [Q_W-1:0] want_pos, logic [Q_W-1:0] want_inc);
    directed_row_t row;
    row.req.element_index = idx;
    row.req.gradient      = grad;
    row.req.position      = pos;
    row.known             = known;
    row.want.out_index    = idx;
    row.want.new_position = want_pos;
    row.want.new_increment = want_inc;
    directed_rows.push_back(row);
  endtask

  // Streams of requests per register setting. Most streams walk one element
  // through a well-formed descent: a negative gradient first to make the
  // increment positive, then small positive gradients so that the gain keeps
  // shrinking towards the clamp. The rest are noise streams over any element.
  task automatic random_phase(int count);
    int              sent, run_len;
    bit              shaped;
    logic [IDX_W-1:0] idx;
    in_item_t        req;
    sent = 0;
    while (sent < count) begin
      run_len = $urandom_range(1, 12);
      shaped  = ($urandom_range(0, 9) < 6);
      idx     = ($urandom_range(0, 9) < 7) ? IDX_W'($urandom_range(0, 31))
                                           : IDX_W'($urandom_range(0, IDX_SPAN - 1));
      for (int k = 0; k < run_len && sent < count; k++) begin
        if (!shaped && $urandom_range(0, 1)) idx = IDX_W'($urandom_range(0, IDX_SPAN - 1));
        req.element_index = idx;
        if (!shaped)
          req.gradient = draw_value();
        else if (k == 0)
          req.gradient = -(draw_magnitude(31) | 32'd1);
        else if ($urandom_range(0, 9) == 0)
          req.gradient = '0;
        else
          req.gradient = draw_magnitude(10) + 32'd1;
        req.position = draw_value();
        send_request(req, 1'b0, '0);
        sent++;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result side: drain with random stalls and check against the oldest request
  // ---------------------------------------------------------------------------
  initial begin
    int        gap;
    bit        steady;
    out_item_t got, want;
    steady = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (results_seen % 32 == 0) steady = ($urandom_range(0, 3) == 0);
      gap = steady ? 0 : $urandom_range(0, 19);
      if (gap > 0) begin
        pop = 1'b0;
        repeat (gap) @(negedge clk);
      end
      pop = 1'b1;
      do @(posedge clk); while (empty !== 1'b0);
      got = result;
      results_seen++;
      if (pending_updates.size() == 0) begin
        $error("result for element %0d with no request outstanding", got.out_index);
        fail_count++;
      end else begin
        want = pending_updates.pop_front();
        if (got.out_index !== want.out_index) begin
          $error("out_index: expected %0d, got %0d", want.out_index, got.out_index);
          fail_count++;
        end
        if (got.new_position !== want.new_position) begin
          $error("new_position: expected %0d, got %0d", want.new_position, got.new_position);
          fail_count++;
        end
        if (got.new_increment !== want.new_increment) begin
          $error("new_increment: expected %0d, got %0d", want.new_increment, got.new_increment);
          fail_count++;
        end
      end
      @(negedge clk);
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: abandon the run when no request moves on either side for too long
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst || (push && full === 1'b0) || (pop && empty === 1'b0))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
               STALL_LIMIT, pending_updates.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    logic [CFG_DATA_W-1:0] mom, lr, floor_gain;

    momentum_q      = MOMENTUM_RESET;
    learning_rate_q = LEARNING_RATE_RESET;
    min_gain_q      = MIN_GAIN_RESET;
    for (int i = 0; i < ELEMS; i++) begin
      gain_of[i]      = GAIN_ONE;
      increment_of[i] = 0;
    end

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // A write to the unused slot must leave the reset settings in force, which
    // the typed-in results below rely on
    write_register(REG_NONE, 24'hFF_FFFF);

    // Reset settings: gain 1.0, increment 0, momentum 0.5, rate 200.0
    add_row(12'd0,    32'd0,        32'd0,        1'b1, 32'd0,        32'd0);
    add_row(12'd1,    32'd1,        32'd0,        1'b1, -32'sd240,    -32'sd240);
    // Same element as the next request, which may find its update still in flight
    add_row(12'd1,    -32'sd1,      32'd5,        1'b0, '0, '0);
    // Rails: the gradient term swamps everything and the increment saturates
    add_row(12'd4095, Q_MAX,        Q_MAX,        1'b1, -32'sd1,      Q_MIN);
    add_row(12'd4094, Q_MIN,        Q_MIN,        1'b1, -32'sd1,      Q_MAX);
    // Zero gradient on a fresh element: position passes straight through
    add_row(12'd2,    32'd0,        Q_MAX,        1'b1, Q_MAX,        32'd0);
    add_row(12'd3,    32'd0,        Q_MIN,        1'b1, Q_MIN,        32'd0);
    // Zero gradient on a saturated increment: momentum term alone
    add_row(12'd4095, 32'd0,        32'd0,        1'b0, '0, '0);
    // Positive gradient on a positive increment shrinks the gain
    add_row(12'd4094, 32'd1,        32'd0,        1'b0, '0, '0);
    // One element walked through a descent: big kick, then repeated shrinks
    add_row(12'd20,   Q_MIN,        32'd0,        1'b0, '0, '0);
    for (int k = 0; k < 6; k++)
      add_row(12'd20, 32'd1,        32'd0,        1'b0, '0, '0);
    add_row(12'd20,   32'd0,        32'd0,        1'b0, '0, '0);
    add_row(12'd5,    32'h5A5A_5A5A, 32'hA5A5_A5A5, 1'b0, '0, '0);
    add_row(12'd6,    32'hA5A5_A5A5, 32'h5A5A_5A5A, 1'b0, '0, '0);
    add_row(12'd2730, 32'h0001_0000, 32'h0000_8000, 1'b0, '0, '0);
    settings_used = 1;

    foreach (directed_rows[i])
      send_request(directed_rows[i].req, directed_rows[i].known, directed_rows[i].want);

    // Random streams under a series of settings, both extremes among them
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin mom = 24'd0;      lr = 24'd0;        floor_gain = 24'd0;     end
        1: begin mom = 24'hFF_FFFF; lr = 24'hFF_FFFF; floor_gain = 24'hFF_FFFF; end
        2: begin mom = 24'd52429;  lr = 24'd13107200; floor_gain = 24'd655;   end
        3: begin mom = 24'd65536;  lr = 24'd65536;    floor_gain = 24'd65536; end
        4, 5: begin
          mom        = 24'($urandom_range(0, 24'h1_FFFF));
          lr         = 24'($urandom & 24'hFF_FFFF);
          floor_gain = 24'($urandom_range(0, 65536));
        end
        default: begin mom = 24'd32768; lr = 24'd655360; floor_gain = 24'd3276; end
      endcase
      wait_idle();
      if (p == 1) write_register(REG_NONE, 24'($urandom & 24'hFF_FFFF));
      write_register(REG_MOMENTUM, mom);
      write_register(REG_LEARNING_RATE, lr);
      write_register(REG_MIN_GAIN, floor_gain);
      settings_used++;
      random_phase(ITEMS_PER_PHASE);
    end

    wait_idle();

    $display("%0d requests and %0d results over %0d register settings",
             requests_sent, results_seen, settings_used);
    $display("gain shrink taken %0d times, minimum-gain clamp taken %0d times",
             shrink_count, clamp_count);
    if (fail_count == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule

// ===== sim.f =====
design/agmu_pkg.sv
design/agmu_fifo.sv
design/agmu_front.sv
design/agmu_back.sv
design/adaptive_gain_momentum_update_unit.sv
design/agmu_checker.sv
tb/sv/testbench.sv
